[hw/rtl/bpe_pkg.sv]
// Shared constants, result codes and controller/datapath interface types of the byte pair expander.
`default_nettype none

package bpe_pkg;

  // Defaults for the top-level parameters.
  localparam int STACK_DEPTH_DEF = 60;
  localparam int HEADER_SKIP_DEF = 64;

  // At most this many results come from one data word.
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Pair table size, indexed by a full byte.
  localparam int TABLE_SIZE = 256;

  // Result status codes.
  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_TABLE_ERR = 2'd1;
  localparam logic [1:0] ST_STACK_ERR = 2'd2;

  // Source of a loaded result.
  typedef enum logic [1:0] {
    OSEL_CUR,
    OSEL_HELD,
    OSEL_TABLE_ERR,
    OSEL_STACK_ERR
  } out_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     skip_inc;
    logic     clear_pairs;
    logic     ctrl_load;
    logic     left_wr;
    logic     right_wr;
    logic     fin_entry;
    logic     cnt_hi;
    logic     cnt_lo;
    logic     data_dec;
    logic     exp_start;
    logic     exp_push;
    logic     exp_pop;
    logic     hold;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } bpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_done;
    logic ctrl_end;
    logic ctrl_over;
    logic left_pair;
    logic tpos_last;
    logic run_last;
    logic cnt_zero;
    logic data_last;
    logic cur_pair;
    logic no_room;
    logic sp_zero;
    logic res_near_full;
    logic res_full;
    logic out_free;
  } bpe_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bpe_dpath.sv]
// Datapath of the byte pair expander: counters, pair table, expansion stack and result register.
`default_nettype none

module bpe_dpath #(
  parameter int STACK_DEPTH = bpe_pkg::STACK_DEPTH_DEF,
  parameter int HEADER_SKIP = bpe_pkg::HEADER_SKIP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  bpe_pkg::bpe_cmd_t   cmd,
  output bpe_pkg::bpe_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic [1:0]          status,
  output logic                last
);
  import bpe_pkg::*;

  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int SPW1 = SPW + 1;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SKW  = (HEADER_SKIP > 0) ? $clog2(HEADER_SKIP + 1) : 1;
  localparam logic [SPW:0]     DEPTH_W  = SPW1'(STACK_DEPTH);
  localparam logic [SKW-1:0]   SKIP_END = SKW'(HEADER_SKIP);

  logic [SKW-1:0]          skip_count;
  logic [8:0]              table_pos;
  logic [7:0]              run_left;
  logic [15:0]             data_left;
  logic [TABLE_SIZE-1:0]   is_pair;
  logic [7:0]              left_mem  [TABLE_SIZE];
  logic [7:0]              right_mem [TABLE_SIZE];
  logic [7:0]              stack_mem [STACK_DEPTH];
  logic [7:0]              left_rd;
  logic [7:0]              right_rd;
  logic [7:0]              stack_rd;
  logic [7:0]              cur;
  logic [7:0]              held_byte;
  logic [SPW-1:0]          sp;
  logic [SPW-1:0]          sp_dec;
  logic [RES_CNT_W-1:0]    res_cnt;
  logic [8:0]              ctrl_pos;
  logic [8:0]              ctrl_step;

  assign sp_dec = sp - SPW'(1);

  // A control byte above 127 skips (value - 127) entries; otherwise it opens a run.
  assign ctrl_step = in_byte[7] ? ({1'b0, in_byte} - 9'd127) : 9'd0;
  assign ctrl_pos  = table_pos + ctrl_step;

  always_comb begin
    stat.hdr_done      = (skip_count >= SKIP_END);
    stat.ctrl_end      = (ctrl_pos == 9'd256);
    stat.ctrl_over     = (ctrl_pos > 9'd256);
    stat.left_pair     = (in_byte != table_pos[7:0]);
    stat.tpos_last     = (table_pos[7:0] == 8'hFF);
    stat.run_last      = (run_left == 8'd1);
    stat.cnt_zero      = (data_left[15:8] == 8'd0) && (in_byte == 8'd0);
    stat.data_last     = (data_left == 16'd1);
    stat.cur_pair      = is_pair[cur];
    stat.no_room       = ({1'b0, sp} + SPW1'(2)) > DEPTH_W;
    stat.sp_zero       = (sp == '0);
    stat.res_near_full = (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
    stat.res_full      = (res_cnt == RES_CNT_W'(MAX_RESULTS));
    stat.out_free      = !out_valid || out_ready;
  end

  // Table and block bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= '0;
      table_pos  <= '0;
      run_left   <= '0;
      data_left  <= '0;
      is_pair    <= '0;
    end else begin
      if (cmd.skip_inc) begin
        skip_count <= skip_count + SKW'(1);
      end
      if (cmd.clear_pairs) begin
        is_pair   <= '0;
        table_pos <= '0;
        run_left  <= '0;
      end
      if (cmd.ctrl_load) begin
        table_pos <= ctrl_pos;
        run_left  <= in_byte[7] ? 8'd1 : (in_byte + 8'd1);
      end
      if (cmd.left_wr) begin
        is_pair[table_pos[7:0]] <= stat.left_pair;
      end
      if (cmd.fin_entry) begin
        table_pos <= table_pos + 9'd1;
        run_left  <= run_left - 8'd1;
      end
      if (cmd.cnt_hi) begin
        data_left <= {in_byte, 8'h00};
      end
      if (cmd.cnt_lo) begin
        data_left[7:0] <= in_byte;
      end
      if (cmd.data_dec) begin
        data_left <= data_left - 16'd1;
      end
    end
  end

  // Pair table memories with registered reads at the current byte.
  always_ff @(posedge clk) begin
    if (cmd.left_wr) begin
      left_mem[table_pos[7:0]] <= in_byte;
    end
    if (cmd.right_wr) begin
      right_mem[table_pos[7:0]] <= in_byte;
    end
    left_rd  <= left_mem[cur];
    right_rd <= right_mem[cur];
  end

  // Expansion stack memory; the read always looks at the top entry.
  always_ff @(posedge clk) begin
    if (cmd.exp_push) begin
      stack_mem[sp[AW-1:0]] <= right_rd;
    end
    stack_rd <= stack_mem[sp_dec[AW-1:0]];
  end

  // Expansion walk. A pair pushes its right byte and continues with its left byte
  // directly, which is the same as pushing both and popping the left one.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      res_cnt <= '0;
    end else begin
      if (cmd.exp_start) begin
        sp      <= '0;
        res_cnt <= '0;
      end
      if (cmd.exp_push) begin
        sp <= sp + SPW'(1);
      end
      if (cmd.exp_pop) begin
        sp <= sp_dec;
      end
      if (cmd.hold || (cmd.out_load && (cmd.out_sel == OSEL_CUR))) begin
        res_cnt <= res_cnt + RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      cur <= in_byte;
    end else if (cmd.exp_push) begin
      cur <= left_rd;
    end else if (cmd.exp_pop) begin
      cur <= stack_rd;
    end
    if (cmd.hold) begin
      held_byte <= cur;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      unique case (cmd.out_sel)
        OSEL_CUR: begin
          out_byte <= cur;
          status   <= ST_DATA;
        end
        OSEL_HELD: begin
          out_byte <= held_byte;
          status   <= ST_DATA;
        end
        OSEL_TABLE_ERR: begin
          out_byte <= 8'd0;
          status   <= ST_TABLE_ERR;
        end
        OSEL_STACK_ERR: begin
          out_byte <= 8'd0;
          status   <= ST_STACK_ERR;
        end
        default: begin
          out_byte <= 8'd0;
          status   <= ST_DATA;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bpe_ctrl.sv]
// Controller state machine of the byte pair expander.
`default_nettype none

module bpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpe_pkg::bpe_stat_t  stat,
  output bpe_pkg::bpe_cmd_t   cmd
);
  import bpe_pkg::*;

  typedef enum logic [3:0] {
    S_HEADER,
    S_CTRL,
    S_LEFT,
    S_RIGHT,
    S_CNT_HI,
    S_CNT_LO,
    S_DATA,
    S_FETCH,
    S_EVAL,
    S_FLUSH,
    S_HALT
  } state_t;

  state_t state;
  state_t state_next;
  state_t fin_state;
  state_t ctrl_state;
  logic   idle;
  logic   accept;

  assign idle = (state == S_HEADER) || (state == S_CTRL) || (state == S_LEFT) ||
                (state == S_RIGHT) || (state == S_CNT_HI) || (state == S_CNT_LO) ||
                (state == S_DATA) || (state == S_HALT);
  assign in_ready = idle && stat.out_free;
  assign accept   = in_valid && in_ready;

  // Where the table goes once an entry is complete, and after a control word.
  assign fin_state  = stat.tpos_last ? (stat.run_last ? S_CNT_HI : S_HALT)
                                     : (stat.run_last ? S_CTRL : S_LEFT);
  assign ctrl_state = stat.ctrl_over ? S_HALT : (stat.ctrl_end ? S_CNT_HI : S_LEFT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_HEADER, S_CTRL: begin
        if (accept) begin
          if ((state == S_HEADER) && !stat.hdr_done) begin
            cmd.skip_inc = 1'b1;
          end else begin
            cmd.clear_pairs = (state == S_HEADER);
            cmd.ctrl_load   = 1'b1;
            cmd.out_load    = stat.ctrl_over;
            cmd.out_sel     = OSEL_TABLE_ERR;
            cmd.out_last    = 1'b1;
            state_next      = ctrl_state;
          end
        end
      end
      S_LEFT: begin
        if (accept) begin
          cmd.left_wr = 1'b1;
          if (stat.left_pair) begin
            state_next = S_RIGHT;
          end else begin
            cmd.fin_entry = 1'b1;
            cmd.out_load  = stat.tpos_last && !stat.run_last;
            cmd.out_sel   = OSEL_TABLE_ERR;
            cmd.out_last  = 1'b1;
            state_next    = fin_state;
          end
        end
      end
      S_RIGHT: begin
        if (accept) begin
          cmd.right_wr  = 1'b1;
          cmd.fin_entry = 1'b1;
          cmd.out_load  = stat.tpos_last && !stat.run_last;
          cmd.out_sel   = OSEL_TABLE_ERR;
          cmd.out_last  = 1'b1;
          state_next    = fin_state;
        end
      end
      S_CNT_HI: begin
        if (accept) begin
          cmd.cnt_hi = 1'b1;
          state_next = S_CNT_LO;
        end
      end
      S_CNT_LO: begin
        if (accept) begin
          cmd.cnt_lo = 1'b1;
          if (stat.cnt_zero) begin
            cmd.clear_pairs = 1'b1;
            state_next      = S_CTRL;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.exp_start = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        priority if (stat.cur_pair && !stat.no_room) begin
          cmd.exp_push = 1'b1;
          state_next   = S_FETCH;
        end else if (stat.cur_pair) begin
          // Stack full: a held data word goes out before the error.
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            if (stat.res_full) begin
              cmd.out_sel  = OSEL_HELD;
              cmd.out_last = 1'b0;
              state_next   = S_FLUSH;
            end else begin
              cmd.out_sel  = OSEL_STACK_ERR;
              cmd.out_last = 1'b1;
              state_next   = S_HALT;
            end
          end
        end else if (stat.res_full) begin
          // One plain byte too many: the error takes the held word's place.
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_STACK_ERR;
            cmd.out_last = 1'b1;
            state_next   = S_HALT;
          end
        end else if (stat.sp_zero) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_CUR;
            cmd.out_last = 1'b1;
            cmd.data_dec = 1'b1;
            if (stat.data_last) begin
              cmd.clear_pairs = 1'b1;
              state_next      = S_CTRL;
            end else begin
              state_next = S_DATA;
            end
          end
        end else if (stat.res_near_full) begin
          cmd.hold    = 1'b1;
          cmd.exp_pop = 1'b1;
          state_next  = S_FETCH;
        end else begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_CUR;
            cmd.out_last = 1'b0;
            cmd.exp_pop  = 1'b1;
            state_next   = S_FETCH;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_STACK_ERR;
          cmd.out_last = 1'b1;
          state_next   = S_HALT;
        end
      end
      S_HALT: begin
        state_next = S_HALT;
      end
      default: begin
        state_next = S_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/byte_pair_expander.sv]
// Top level of the byte pair expander: controller and datapath.
//
// Usage: compressed words enter on in_byte under in_valid/in_ready, starting
// with the word right after the stream's magic. The first HEADER_SKIP words
// are dropped. Each block then brings a pair table, a 16-bit big-endian count
// and that many data words. Every data word expands into plain bytes, each
// sent on out_byte/status/last under out_valid/out_ready; last marks the
// final result of one input word. Status 1 reports a pair table overrun and
// status 2 an expansion stack overflow (or more than 64 results from one
// word); after either, words are still taken but give no results until reset.
// Header, table and count words are taken while the result register is free;
// a data word is taken only once the last one is fully expanded. Each
// expansion step (one plain byte or one pair) passes a fetch state and an
// evaluate state, since it waits on the registered reads of the pair table
// and the expansion stack.
// Reset (rst, synchronous) returns the block to header skipping and clears
// the pair flags and the result register. When the receiver stalls, the
// result register holds its word and the expansion waits; no word is lost.
`default_nettype none

module byte_pair_expander #(
  parameter int STACK_DEPTH = bpe_pkg::STACK_DEPTH_DEF,
  parameter int HEADER_SKIP = bpe_pkg::HEADER_SKIP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last
);
  import bpe_pkg::*;

  bpe_cmd_t  cmd;
  bpe_stat_t stat;

  // The controller sequences header, table, count and expansion steps.
  bpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the table, the stack and the result register.
  bpe_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .HEADER_SKIP (HEADER_SKIP)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

[hw/rtl/bpe_checker.sv]
// Port-level checker of the byte pair expander and its bind to the top level.
`default_nettype none

module bpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic       last
);
  import bpe_pkg::*;

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_byte, status, last}))
    else $error("result word changed while stalled");

  // Error words carry a zero byte and close the results of their input word.
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TABLE_ERR || status == ST_STACK_ERR) |->
      (out_byte == 8'd0) && last)
    else $error("malformed error word");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DATA || status == ST_TABLE_ERR || status == ST_STACK_ERR))
    else $error("undefined status code");

  // Once an error word is taken the block is halted and sends nothing more.
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (status != ST_DATA) |=> !out_valid)
    else $error("result after an error");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind byte_pair_expander bpe_checker u_bpe_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the byte pair expander with a built-in decoder model.
`timescale 1ns / 100ps

module testbench;
  import bpe_pkg::*;

  // The block is built with its default sizes, and the decoder model below uses the same ones.
  localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int HEADER_SKIP  = HEADER_SKIP_DEF;
  localparam int RANDOM_WORDS = 310;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  // Pair expansions built by the random blocks stay at or below this size. That keeps every
  // expansion below the result limit and the left chains well short of the stack depth.
  localparam int MAX_GROW     = 48;

  // One result of the block, and one word of the compressed stream as the sender holds it.
  // A word marked as given carries its single result, typed in by hand.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       given;
    logic [7:0] g_data;
    logic [1:0] g_code;
  } stream_word_t;

  typedef enum logic [2:0] {
    HDR_SKIP, TBL_CTRL, TBL_LEFT, TBL_RIGHT, CNT_HIGH, CNT_LOW, DATA_WORDS, HALTED
  } decode_phase_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  byte_pair_expander #(
    .STACK_DEPTH(STACK_DEPTH),
    .HEADER_SKIP(HEADER_SKIP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .status(status),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The decoder model keeps its own copy of the block's state.
  decode_phase_t d_phase = HDR_SKIP;
  int            d_skipped = 0;
  int            d_pos = 0;
  int            d_run = 0;
  int            d_count = 0;
  logic          d_pair [TABLE_SIZE];
  logic [7:0]    d_left [TABLE_SIZE];
  logic [7:0]    d_right [TABLE_SIZE];

  result_t      word_out [$];     // results of the word that was just decoded
  result_t      due_results [$];  // results still owed by the block, oldest first
  stream_word_t stream_q [$];     // words waiting to be offered to the block
  stream_word_t cur_word;         // the word now on in_byte
  stream_word_t directed_rows [24];

  // Stream generator bookkeeping: expansion size of each table index in the block being
  // built, and the indexes that hold pairs so far.
  int         grow [TABLE_SIZE];
  logic [7:0] pair_idx [$];
  int         words_queued = 0;

  int   mismatches = 0;
  int   cycle_cnt = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic calm = 1'b0;

  initial begin
    foreach (d_pair[i]) d_pair[i] = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------------------

  // A new block clears all pair flags and starts reading its table at position 0.
  function automatic void open_block();
    foreach (d_pair[i]) d_pair[i] = 1'b0;
    d_pos = 0;
    d_run = 0;
    d_phase = TBL_CTRL;
  endfunction

  // The table ran past its last position: one error result, and the block stops decoding.
  function automatic void table_overrun();
    d_phase = HALTED;
    word_out.push_back('{data: 8'h00, code: ST_TABLE_ERR, last: 1'b1});
  endfunction

  // A control word either skips ahead and reads one entry, or starts a run of v+1 entries.
  function automatic void read_ctrl(input logic [7:0] v);
    int pos;
    pos = d_pos;
    if (v > 8'd127) begin
      pos += int'(v) - 127;
      d_run = 1;
    end else begin
      d_run = int'(v) + 1;
    end
    if (pos == TABLE_SIZE) begin
      d_pos = pos;
      d_phase = CNT_HIGH;
    end else if (pos > TABLE_SIZE) begin
      table_overrun();
    end else begin
      d_pos = pos;
      d_phase = TBL_LEFT;
    end
  endfunction

  // One entry is complete. Reaching the table end with entries left in the run is an overrun.
  function automatic void close_entry();
    d_pos++;
    d_run = (d_run - 1) & 255;
    if (d_pos >= TABLE_SIZE) begin
      if (d_run != 0) table_overrun();
      else d_phase = CNT_HIGH;
    end else begin
      d_phase = (d_run == 0) ? TBL_CTRL : TBL_LEFT;
    end
  endfunction

  // Decodes one accepted word into word_out.
  function automatic void decode_word(input logic [7:0] v);
    logic [7:0] cur;
    logic [7:0] stk [$];
    result_t    tail;
    word_out.delete();
    case (d_phase)
      HDR_SKIP: begin
        if (d_skipped < HEADER_SKIP) begin
          d_skipped++;
        end else begin
          // The word after the header is already the first control word of the table.
          open_block();
          read_ctrl(v);
        end
      end
      TBL_CTRL: read_ctrl(v);
      TBL_LEFT: begin
        d_left[d_pos[7:0]] = v;
        if (v != d_pos[7:0]) begin
          d_pair[d_pos[7:0]] = 1'b1;
          d_phase = TBL_RIGHT;
        end else begin
          d_pair[d_pos[7:0]] = 1'b0;
          close_entry();
        end
      end
      TBL_RIGHT: begin
        d_right[d_pos[7:0]] = v;
        close_entry();
      end
      CNT_HIGH: begin
        d_count = int'(v) << 8;
        d_phase = CNT_LOW;
      end
      CNT_LOW: begin
        d_count = d_count | int'(v);
        if (d_count == 0) open_block();
        else d_phase = DATA_WORDS;
      end
      DATA_WORDS: begin
        // Depth-first expansion, left byte first. A pair pushes its right byte, then its left
        // byte, so the left byte is popped next.
        cur = v;
        while (1) begin
          if (d_pair[cur]) begin
            if (stk.size() + 2 > STACK_DEPTH) begin
              word_out.push_back('{data: 8'h00, code: ST_STACK_ERR, last: 1'b0});
              d_phase = HALTED;
              break;
            end
            stk.push_back(d_right[cur]);
            stk.push_back(d_left[cur]);
          end else begin
            if (word_out.size() >= MAX_RESULTS) begin
              // The last result slot turns into a stack error.
              word_out[MAX_RESULTS - 1] = '{data: 8'h00, code: ST_STACK_ERR, last: 1'b0};
              d_phase = HALTED;
              break;
            end
            word_out.push_back('{data: cur, code: ST_DATA, last: 1'b0});
          end
          if (stk.size() == 0) break;
          cur = stk.pop_back();
        end
        tail = word_out.pop_back();
        tail.last = 1'b1;
        word_out.push_back(tail);
        if (d_phase != HALTED) begin
          d_count--;
          if (d_count == 0) open_block();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------------------

  function automatic void queue_word(input logic [7:0] b);
    stream_q.push_back('{data: b, given: 1'b0, g_data: 8'h00, g_code: ST_DATA});
    words_queued++;
  endfunction

  function automatic int at_most(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Closes a table from position pos with the fewest words: skip-by-128 steps, each of which
  // has to read one plain entry, and then a skip that lands exactly on the table end.
  function automatic void end_table(input int pos);
    while (TABLE_SIZE - pos > 128) begin
      queue_word(8'hFF);
      pos += 128;
      queue_word(8'(pos));
      pos++;
    end
    if (pos < TABLE_SIZE) queue_word(8'(127 + TABLE_SIZE - pos));
  endfunction

  // A pair may only refer to lower indexes. That keeps the pair graph free of cycles.
  // Pairs already in the table are favored, so that expansions nest.
  function automatic logic [7:0] lower_ref(input int pos);
    if (pair_idx.size() != 0 && $urandom_range(1) == 1)
      return pair_idx[$urandom_range(pair_idx.size() - 1)];
    return 8'($urandom_range(pos - 1));
  endfunction

  // Writes the table entry at pos, which is either a pair or a plain byte (left byte equal to
  // its index).
  function automatic void add_entry(input int pos);
    logic [7:0] l;
    logic [7:0] r;
    if (pos > 0 && $urandom_range(99) < 55) begin
      l = lower_ref(pos);
      r = lower_ref(pos);
      if (grow[l] + grow[r] <= MAX_GROW) begin
        queue_word(l);
        queue_word(r);
        grow[pos] = grow[l] + grow[r];
        pair_idx.push_back(8'(pos));
        return;
      end
    end
    queue_word(8'(pos));
  endfunction

  // Waits at the falling edge, where nothing is changing, until the block owes nothing.
  task automatic wait_drained();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------
  // Sender: offers queued words. It idles now and then, except in the calm stretch. The
  // model is updated at the edge that accepts a word, using the word that was on the port.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word(in_byte);
        if (cur_word.given) begin
          due_results.push_back('{data: cur_word.g_data, code: cur_word.g_code, last: 1'b1});
        end else begin
          foreach (word_out[i]) due_results.push_back(word_out[i]);
        end
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          cur_word = stream_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= cur_word.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: checks each result against the oldest owed one. It idles now and then, except
  // in the calm stretch, and it holds off for a long stretch once when asked.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: byte %h status %0d last %0b",
                   $time, out_byte, status, last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if ({out_byte, status, last} !== want) begin
            $display("%0t: expected byte %h status %0d last %0b, got byte %h status %0d last %0b",
                     $time, want.data, want.code, want.last, out_byte, status, last);
            mismatches++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, due_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  initial begin
    int pos;
    int room;
    int k;
    int len;
    int pick;
    int n_data;
    int blocks;

    // Block A uses plain entry 0, pair 2 = (00, FF) and pair 3 = (2, 2), which expands to
    // 00 FF 00 FF. Its table ends on a skip that lands exactly on position 256.
    // Block B ends on a run that fills the last table position, and it has a count of zero.
    directed_rows = '{
      '{8'h00, 1'b0, 8'h00, ST_DATA},  // run of one entry at position 0
      '{8'h00, 1'b0, 8'h00, ST_DATA},  // entry 0, plain
      '{8'h80, 1'b0, 8'h00, ST_DATA},  // skip to 2, one entry
      '{8'h00, 1'b0, 8'h00, ST_DATA},  // entry 2 left
      '{8'hFF, 1'b0, 8'h00, ST_DATA},  // entry 2 right
      '{8'h01, 1'b0, 8'h00, ST_DATA},  // run of two entries at 3
      '{8'h02, 1'b0, 8'h00, ST_DATA},  // entry 3 left
      '{8'h02, 1'b0, 8'h00, ST_DATA},  // entry 3 right
      '{8'h04, 1'b0, 8'h00, ST_DATA},  // entry 4, plain
      '{8'hFF, 1'b0, 8'h00, ST_DATA},  // longest skip, to 133
      '{8'h85, 1'b0, 8'h00, ST_DATA},  // entry 133, plain
      '{8'hF9, 1'b0, 8'h00, ST_DATA},  // skip from 134 to the table end
      '{8'h00, 1'b0, 8'h00, ST_DATA},  // count, high byte
      '{8'h04, 1'b0, 8'h00, ST_DATA},  // count, low byte
      '{8'h00, 1'b1, 8'h00, ST_DATA},  // plain zero byte
      '{8'hFF, 1'b1, 8'hFF, ST_DATA},  // plain all-ones byte
      '{8'h02, 1'b0, 8'h00, ST_DATA},  // one pair
      '{8'h03, 1'b0, 8'h00, ST_DATA},  // nested pairs; count runs out, new block
      '{8'hFF, 1'b0, 8'h00, ST_DATA},  // skip to 128
      '{8'h80, 1'b0, 8'h00, ST_DATA},  // entry 128, plain
      '{8'hFD, 1'b0, 8'h00, ST_DATA},  // skip to 255
      '{8'hFF, 1'b0, 8'h00, ST_DATA},  // entry 255, plain; the table is full
      '{8'h00, 1'b0, 8'h00, ST_DATA},  // count, high byte
      '{8'h00, 1'b0, 8'h00, ST_DATA}   // count of zero
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The header words carry nothing, so any value will do.
    repeat (HEADER_SKIP) queue_word(8'($urandom));
    foreach (directed_rows[i]) begin
      stream_q.push_back(directed_rows[i]);
      words_queued++;
    end
    // The sender pauses until the directed words have fully drained.
    wait_drained();

    // Random part: well-formed blocks with random tables, counts and data words.
    blocks = 0;
    while (blocks < 6 ||
           words_queued < HEADER_SKIP + $size(directed_rows) + RANDOM_WORDS) begin
      calm = (blocks >= 3 && blocks < 5);
      // Block 2 is sent while the receiver holds off. The block backs up and stops taking
      // words, while the sender keeps offering them.
      if (blocks == 2) hold_req = 1'b1;
      foreach (grow[i]) grow[i] = 1;
      pair_idx.delete();
      pos = 0;
      while (pos < TABLE_SIZE) begin
        room = TABLE_SIZE - pos;
        pick = $urandom_range(99);
        if (pick < 30) begin
          end_table(pos);
          pos = TABLE_SIZE;
        end else if (pick < 55) begin
          // A skip either lands on the table end or is followed by one entry.
          k = ($urandom_range(4) == 0) ? at_most(128, room)
                                       : $urandom_range(at_most(16, room), 1);
          queue_word(8'(127 + k));
          pos += k;
          if (pos < TABLE_SIZE) begin
            add_entry(pos);
            pos++;
          end
        end else begin
          len = ($urandom_range(9) == 0) ? at_most(128, room)
                                         : $urandom_range(at_most(8, room), 1);
          queue_word(8'(len - 1));
          repeat (len) begin
            add_entry(pos);
            pos++;
          end
        end
      end

      pick = $urandom_range(99);
      if (blocks == 2) n_data = 12;
      else if (pick < 10) n_data = 0;
      else if (pick < 90) n_data = $urandom_range(6, 1);
      else n_data = $urandom_range(24, 10);
      queue_word(8'h00);
      queue_word(8'(n_data));
      repeat (n_data) begin
        if (pair_idx.size() != 0 && $urandom_range(99) < 60)
          queue_word(pair_idx[$urandom_range(pair_idx.size() - 1)]);
        else
          queue_word(8'($urandom));
      end
      blocks++;

      // Keep the backlog short, so that the idle patterns spread over the whole run.
      while (stream_q.size() > 8) @(negedge clk);
      if (blocks == 5) wait_drained();
    end
    calm = 1'b0;

    // An error halts the block until reset. There is one reset per run, so only one of the
    // error cases is picked, at the very end.
    case ($urandom_range(3))
      0: begin
        // A skip past the table end.
        queue_word(8'hFF);
        queue_word(8'h80);
        queue_word(8'hFF);
      end
      1: begin
        // A run of three entries that starts at 255.
        queue_word(8'hFF);
        queue_word(8'h80);
        queue_word(8'hFC);
        queue_word(8'hFE);
        queue_word(8'h02);
        queue_word(8'hFF);
      end
      2: begin
        // Pairs 1 and 2 name each other as left byte, so expanding them never ends. Pair 3
        // emits a plain byte before it reaches them, and the overflow follows that byte.
        queue_word(8'h80);
        queue_word(8'h02);
        queue_word(8'h55);
        queue_word(8'h00);
        queue_word(8'h01);
        queue_word(8'hAA);
        queue_word(8'h00);
        queue_word(8'h41);
        queue_word(8'h01);
        end_table(4);
        queue_word(8'h00);
        queue_word(8'h02);
        queue_word(8'h41);
        queue_word(8'h03);
      end
      default: begin
        // Pairs 1 through 7 double at each level, so byte 7 expands to 128 plain bytes.
        // That is past the result limit.
        queue_word(8'h80);
        queue_word(8'h30);
        queue_word(8'h31);
        queue_word(8'h05);
        for (k = 2; k <= 7; k++) begin
          queue_word(8'(k - 1));
          queue_word(8'(k - 1));
        end
        end_table(8);
        queue_word(8'h00);
        queue_word(8'h01);
        queue_word(8'h07);
      end
    endcase
    // Words after the error are still taken but give no results.
    repeat (6) queue_word(8'($urandom));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
